// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file gmpr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define GMPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that also runs during reset.
`define GMPR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/gmpr_pkg.sv =====
// Shared constants, tables and types of the geodetic meters-per-radian block.
package gmpr_pkg;

    localparam int ANGLE_ITER_DFLT = 24;
    localparam int ATAN_MAX        = 32;
    localparam int XY_W            = 33;
    localparam int Q30_W           = 31;
    localparam int H_W             = 24;

    localparam logic [32:0] A_RESET      = 33'd6378137000;
    localparam logic [26:0] E2_RESET     = 27'd28752143;
    // floor(floor(pi * 2^62) / 1800000000)
    localparam logic [32:0] DEG_TO_RAD_C = 33'd8048910508;
    localparam logic [29:0] LAT_MAX      = 30'd900000000;
    localparam logic [32:0] OUT_MAX      = 33'd6500000000;

    localparam logic signed [XY_W-1:0] INV_GAIN = 33'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30  = 33'sd1073741824;

    localparam logic [30:0] ATAN_Q30 [ATAN_MAX] = '{
        31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6,
        31'h03FEAB76, 31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55,
        31'h003FFFEA, 31'h001FFFFD, 31'h000FFFFF, 31'h0007FFFF,
        31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF, 31'h00007FFF,
        31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
        31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F,
        31'h0000003F, 31'h0000001F, 31'h0000000F, 31'h00000008,
        31'h00000004, 31'h00000002, 31'h00000001, 31'h00000000
    };

    typedef enum logic [1:0] {
        REG_SEMI_MAJOR = 2'd0,
        REG_ECC_SQ     = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
    } cordic_vec_t;

endpackage

// ===== rtl/gmpr_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation stage.
module gmpr_cordic_cell
    import gmpr_pkg::*;
#(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cordic_vec_t       in_vec,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output cordic_vec_t       out_vec,
    output logic [SIDE_W-1:0] out_side
);

    logic                   valid_reg;
    cordic_vec_t            vec_reg, vec_next;
    logic [SIDE_W-1:0]      side_reg;
    logic signed [XY_W-1:0] xi, yi, zi, dx, dy, at;
    logic                   rot;

    always_comb begin
        xi  = in_vec.x;
        yi  = in_vec.y;
        zi  = in_vec.z;
        dx  = yi >>> STEP;
        dy  = xi >>> STEP;
        at  = $signed({{(XY_W-31){1'b0}}, ATAN_Q30[STEP]});
        rot = !zi[XY_W-1];
        if (rot) begin
            vec_next.x = xi - dx;
            vec_next.y = yi + dy;
            vec_next.z = zi - at;
        end else begin
            vec_next.x = xi + dx;
            vec_next.y = yi - dy;
            vec_next.z = zi + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/gmpr_sqrt_cell.sv =====
// One digit-by-digit square root stage: retires one root bit.
module gmpr_sqrt_cell
    import gmpr_pkg::*;
#(
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [ROOT_W+2:0]   in_rem,
    input  logic [ROOT_W-1:0]   in_root,
    input  logic [2*ROOT_W-1:0] in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [ROOT_W+2:0]   out_rem,
    output logic [ROOT_W-1:0]   out_root,
    output logic [2*ROOT_W-1:0] out_rad,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int REM_W = ROOT_W + 3;
    localparam int RAD_W = 2 * ROOT_W;

    logic              valid_reg;
    logic [REM_W-1:0]  rem_reg, rem_next, rem2, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RAD_W-1:0]  rad_reg;
    logic [SIDE_W-1:0] side_reg;
    logic              ge;

    always_comb begin
        rem2      = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        ge        = rem2 >= trial;
        rem_next  = ge ? (rem2 - trial) : rem2;
        root_next = {in_root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {in_rad[RAD_W-3:0], 2'b00};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/gmpr_div_cell.sv =====
// One restoring division stage: retires one quotient bit.
module gmpr_div_cell
    import gmpr_pkg::*;
#(
    parameter int DIV_W  = 32,
    parameter int Q_W    = 34,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIV_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_quo,
    input  logic [Q_W-1:0]    in_num,
    input  logic [DIV_W-1:0]  in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DIV_W-1:0]  out_rem,
    output logic [Q_W-1:0]    out_quo,
    output logic [Q_W-1:0]    out_num,
    output logic [DIV_W-1:0]  out_div,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [DIV_W-1:0]  rem_reg, rem_next, div_reg;
    logic [Q_W-1:0]    quo_reg, num_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DIV_W:0]    rem2, diff;
    logic              ge;

    // remainder stays below the divisor, so DIV_W bits hold it
    always_comb begin
        rem2     = {in_rem, in_num[Q_W-1]};
        diff     = rem2 - {1'b0, in_div};
        ge       = rem2 >= {1'b0, in_div};
        rem_next = ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= {in_quo[Q_W-2:0], ge};
            num_reg  <= {in_num[Q_W-2:0], 1'b0};
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_num   = num_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/geodetic_meters_per_radian.sv =====
// Meters per radian of latitude and longitude on a configurable ellipsoid.
// One request per clock is accepted unless the output side stalls while the
// last pipeline stage is full; each request returns one result. The pipeline
// is a row of pipeline cells: one CORDIC cell per angle iteration, 32 square
// root cells (one root bit each), 34 cells for the prime vertical radius
// division and 31 cells for the meridian ratio division, plus multiply,
// scaling and saturation stages. The output register decouples the
// result side: while a result waits, new requests are still taken as long as
// the last pipeline stage is empty. Configuration writes take effect at once
// and are meant to be done while no request is in flight.
module geodetic_meters_per_radian
    import gmpr_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DFLT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [32:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_latitude_e7,
    input  logic signed [16:0] s_elevation_dm,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [32:0]        m_mm_per_rad_lat,
    output logic [32:0]        m_mm_per_rad_lon
);

    localparam int N       = ANGLE_ITERATIONS;
    localparam int SQ_N    = 32;
    localparam int D1_Q    = 34;
    localparam int D2_Q    = 31;
    localparam int SIDE1_W = 33 + Q30_W + H_W;
    localparam int SIDE2_W = D1_Q + Q30_W + H_W;

    function automatic logic [Q30_W-1:0] clamp_q30(input logic signed [XY_W-1:0] v);
        logic [Q30_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ONE_Q30) begin
            r = ONE_Q30[Q30_W-1:0];
        end else begin
            r = v[Q30_W-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [32:0] a_reg;
    logic [26:0] e2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg  <= A_RESET;
            e2_reg <= E2_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SEMI_MAJOR: a_reg  <= cfg_wdata;
                REG_ECC_SQ:     e2_reg <= cfg_wdata[26:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic m_valid_reg, out_load, pipe_en, v8_reg;
    assign out_load = !m_valid_reg || m_ready;
    assign pipe_en  = out_load || !v8_reg;
    assign s_ready  = pipe_en;

    // stage 0: magnitude and elevation in mm
    logic [30:0]           lat_u, mag_raw;
    logic [29:0]           mag_c;
    logic signed [H_W-1:0] h_c;

    always_comb begin
        lat_u   = s_latitude_e7;
        mag_raw = lat_u[30] ? (31'd0 - lat_u) : lat_u;
        mag_c   = (mag_raw > {1'b0, LAT_MAX}) ? LAT_MAX : mag_raw[29:0];
        h_c     = H_W'(s_elevation_dm) * H_W'(100);
    end

    logic                  v0_reg, v1_reg, v2_reg;
    logic [29:0]           mag0_reg;
    logic [H_W-1:0]        h0_reg, h1_reg, h2_reg;
    logic [46:0]           ph1_reg;
    logic [45:0]           pl1_reg;
    logic [30:0]           z2_reg;
    logic [62:0]           zsum;

    assign zsum = {ph1_reg, 16'b0} + {17'b0, pl1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mag0_reg <= mag_c;
            h0_reg   <= h_c;
            ph1_reg  <= {17'b0, mag0_reg} * {30'b0, DEG_TO_RAD_C[32:16]};
            pl1_reg  <= {16'b0, mag0_reg} * {30'b0, DEG_TO_RAD_C[15:0]};
            h1_reg   <= h0_reg;
            z2_reg   <= zsum[62:32];
            h2_reg   <= h1_reg;
        end
    end

    // CORDIC row
    cordic_vec_t    cv  [0:N];
    logic           cvl [0:N];
    logic [H_W-1:0] ch  [0:N];

    assign cv[0].x = INV_GAIN;
    assign cv[0].y = '0;
    assign cv[0].z = $signed({2'b0, z2_reg});
    assign cvl[0]  = v2_reg;
    assign ch[0]   = h2_reg;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        gmpr_cordic_cell #(
            .STEP   (i),
            .SIDE_W (H_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (cvl[i]),
            .in_vec    (cv[i]),
            .in_side   (ch[i]),
            .out_valid (cvl[i+1]),
            .out_vec   (cv[i+1]),
            .out_side  (ch[i+1])
        );
    end

    // stages 3..5: clamp, sin^2, 1 - e2 sin^2
    logic                 v3_reg, v4_reg, v5_reg;
    logic [Q30_W-1:0]     cos3_reg, sin3_reg, cos4_reg, cos5_reg;
    logic [H_W-1:0]       h3_reg, h4_reg, h5_reg;
    logic [Q30_W-1:0]     s2_reg;
    logic [32:0]          d5_reg;
    logic [61:0]          sq_prod;
    logic [57:0]          e2_prod;

    assign sq_prod = {31'b0, sin3_reg} * {31'b0, sin3_reg};
    assign e2_prod = {31'b0, e2_reg} * {27'b0, s2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (pipe_en) begin
            v3_reg <= cvl[N];
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cos3_reg <= clamp_q30(cv[N].x);
            sin3_reg <= clamp_q30(cv[N].y);
            h3_reg   <= ch[N];
            s2_reg   <= sq_prod[60:30];
            cos4_reg <= cos3_reg;
            h4_reg   <= h3_reg;
            d5_reg   <= 33'h1_0000_0000 - {5'b0, e2_prod[57:30]};
            cos5_reg <= cos4_reg;
            h5_reg   <= h4_reg;
        end
    end

    // square root row: q = sqrt(d * 2^30)
    logic [SQ_N+2:0]    sq_rem  [0:SQ_N];
    logic [SQ_N-1:0]    sq_root [0:SQ_N];
    logic [2*SQ_N-1:0]  sq_rad  [0:SQ_N];
    logic [SIDE1_W-1:0] sq_side [0:SQ_N];
    logic               sq_vl   [0:SQ_N];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = {1'b0, d5_reg, 30'b0};
    assign sq_side[0] = {d5_reg, cos5_reg, h5_reg};
    assign sq_vl[0]   = v5_reg;

    for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
        gmpr_sqrt_cell #(
            .ROOT_W (SQ_N),
            .SIDE_W (SIDE1_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (sq_vl[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_rad    (sq_rad[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_vl[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // first division row: rn = a * 2^31 / q
    logic [31:0]        d1_rem  [0:D1_Q];
    logic [D1_Q-1:0]    d1_quo  [0:D1_Q];
    logic [D1_Q-1:0]    d1_num  [0:D1_Q];
    logic [31:0]        d1_div  [0:D1_Q];
    logic [SIDE1_W-1:0] d1_side [0:D1_Q];
    logic               d1_vl   [0:D1_Q];

    assign d1_rem[0]  = {2'b0, a_reg[32:3]};
    assign d1_quo[0]  = '0;
    assign d1_num[0]  = {a_reg[2:0], 31'b0};
    assign d1_div[0]  = sq_root[SQ_N];
    assign d1_side[0] = sq_side[SQ_N];
    assign d1_vl[0]   = sq_vl[SQ_N];

    for (genvar i = 0; i < D1_Q; i++) begin : g_div1
        gmpr_div_cell #(
            .DIV_W  (32),
            .Q_W    (D1_Q),
            .SIDE_W (SIDE1_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (d1_vl[i]),
            .in_rem    (d1_rem[i]),
            .in_quo    (d1_quo[i]),
            .in_num    (d1_num[i]),
            .in_div    (d1_div[i]),
            .in_side   (d1_side[i]),
            .out_valid (d1_vl[i+1]),
            .out_rem   (d1_rem[i+1]),
            .out_quo   (d1_quo[i+1]),
            .out_num   (d1_num[i+1]),
            .out_div   (d1_div[i+1]),
            .out_side  (d1_side[i+1])
        );
    end

    // second division row: r = (2^32 - e2) * 2^30 / d
    logic [32:0]        t_num;
    logic [32:0]        d2_rem  [0:D2_Q];
    logic [D2_Q-1:0]    d2_quo  [0:D2_Q];
    logic [D2_Q-1:0]    d2_num  [0:D2_Q];
    logic [32:0]        d2_div  [0:D2_Q];
    logic [SIDE2_W-1:0] d2_side [0:D2_Q];
    logic               d2_vl   [0:D2_Q];

    assign t_num      = 33'h1_0000_0000 - {6'b0, e2_reg};
    assign d2_rem[0]  = {1'b0, t_num[32:1]};
    assign d2_quo[0]  = '0;
    assign d2_num[0]  = {t_num[0], 30'b0};
    assign d2_div[0]  = d1_side[D1_Q][SIDE1_W-1 -: 33];
    assign d2_side[0] = {d1_quo[D1_Q], d1_side[D1_Q][Q30_W+H_W-1:0]};
    assign d2_vl[0]   = d1_vl[D1_Q];

    for (genvar i = 0; i < D2_Q; i++) begin : g_div2
        gmpr_div_cell #(
            .DIV_W  (33),
            .Q_W    (D2_Q),
            .SIDE_W (SIDE2_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (d2_vl[i]),
            .in_rem    (d2_rem[i]),
            .in_quo    (d2_quo[i]),
            .in_num    (d2_num[i]),
            .in_div    (d2_div[i]),
            .in_side   (d2_side[i]),
            .out_valid (d2_vl[i+1]),
            .out_rem   (d2_rem[i+1]),
            .out_quo   (d2_quo[i+1]),
            .out_num   (d2_num[i+1]),
            .out_div   (d2_div[i+1]),
            .out_side  (d2_side[i+1])
        );
    end

    // stages 6..8: R_m, longitude product, saturation
    logic [D1_Q-1:0]       rn;
    logic [D2_Q-1:0]       rr;
    logic [Q30_W-1:0]      cos_d2;
    logic signed [H_W-1:0] h_d2;

    assign rn     = d2_side[D2_Q][SIDE2_W-1 -: D1_Q];
    assign cos_d2 = d2_side[D2_Q][Q30_W+H_W-1:H_W];
    assign h_d2   = $signed(d2_side[D2_Q][H_W-1:0]);
    assign rr     = d2_quo[D2_Q];

    logic                  v6_reg, v7_reg;
    logic [48:0]           rmh6_reg;
    logic [49:0]           rml6_reg;
    logic signed [35:0]    lsum6_reg;
    logic [Q30_W-1:0]      cos6_reg;
    logic signed [H_W-1:0] h6_reg;
    logic [65:0]           rmsum;
    logic [35:0]           rm7;
    logic [34:0]           pos7;
    logic signed [37:0]    lat7_reg;
    logic [49:0]           lph7_reg;
    logic [50:0]           lpl7_reg;
    logic                  neg7_reg;
    logic [66:0]           lonsum;
    logic [36:0]           lonr;
    logic [32:0]           lat_sat, lon_sat, lat8_reg, lon8_reg;

    always_comb begin
        rmsum  = {1'b0, rmh6_reg, 16'b0} + {16'b0, rml6_reg};
        rm7    = rmsum[65:30];
        pos7   = lsum6_reg[34:0];
        lonsum = {1'b0, lph7_reg, 16'b0} + {16'b0, lpl7_reg};
        lonr   = lonsum[66:30];
        if (lat7_reg < 0) begin
            lat_sat = '0;
        end else if (lat7_reg > $signed({5'b0, OUT_MAX})) begin
            lat_sat = OUT_MAX;
        end else begin
            lat_sat = lat7_reg[32:0];
        end
        if (neg7_reg) begin
            lon_sat = '0;
        end else if (lonr > {4'b0, OUT_MAX}) begin
            lon_sat = OUT_MAX;
        end else begin
            lon_sat = lonr[32:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (pipe_en) begin
            v6_reg <= d2_vl[D2_Q];
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rmh6_reg  <= {15'b0, rn} * {34'b0, rr[30:16]};
            rml6_reg  <= {16'b0, rn} * {34'b0, rr[15:0]};
            lsum6_reg <= $signed({2'b0, rn}) + 36'(h_d2);
            cos6_reg  <= cos_d2;
            h6_reg    <= h_d2;
            lat7_reg  <= $signed({2'b0, rm7}) + 38'(h6_reg);
            lph7_reg  <= {15'b0, pos7} * {35'b0, cos6_reg[30:16]};
            lpl7_reg  <= {16'b0, pos7} * {35'b0, cos6_reg[15:0]};
            neg7_reg  <= lsum6_reg[35];
            lat8_reg  <= lat_sat;
            lon8_reg  <= lon_sat;
        end
    end

    // output register
    logic [32:0] lat_out_reg, lon_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            lat_out_reg <= lat8_reg;
            lon_out_reg <= lon8_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_mm_per_rad_lat = lat_out_reg;
    assign m_mm_per_rad_lon = lon_out_reg;

endmodule

// ===== rtl/gmpr_checker.sv =====
// Port-level checks for the geodetic meters-per-radian block.
`include "assert_macros.svh"

module gmpr_checker
    import gmpr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [32:0] m_mm_per_rad_lat,
    input logic [32:0] m_mm_per_rad_lon
);

    `GMPR_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_mm_per_rad_lat) && $stable(m_mm_per_rad_lon), "result changed while stalled")
    `GMPR_ASSERT(a_out_range, m_valid |-> m_mm_per_rad_lat <= OUT_MAX && m_mm_per_rad_lon <= OUT_MAX, "result above saturation limit")
    `GMPR_ASSERT(a_in_free, !m_valid |-> s_ready, "input blocked with empty output")
    `GMPR_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind geodetic_meters_per_radian gmpr_checker u_gmpr_checker (.*);

// ===== tb/geodetic_meters_per_radian_tb.sv =====
// Self-checking testbench for the geodetic meters-per-radian pipeline.
`timescale 1ns / 100ps

module geodetic_meters_per_radian_tb;
    import gmpr_pkg::*;

    localparam logic [1:0]  REG_SPARE_2 = 2'd2;
    localparam logic [1:0]  REG_SPARE_3 = 2'd3;
    localparam logic [63:0] TWO_POW_32  = 64'h1_0000_0000;
    localparam int          DRAIN_CYCLES = ANGLE_ITER_DFLT + 140;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [32:0] lat_mm;
        logic [32:0] lon_mm;
    } radii_t;

    class mpr_scoreboard;
        logic [32:0] axis_mm;
        logic [26:0] ecc_q32;
        radii_t      pending[$];
        int          errors;

        function new();
            axis_mm = A_RESET;
            ecc_q32 = E2_RESET;
            errors  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [32:0] val);
            if (idx == REG_SEMI_MAJOR) begin
                axis_mm = val;
            end else if (idx == REG_ECC_SQ) begin
                ecc_q32 = val[26:0];
            end
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function logic [32:0] saturate(longint v);
            if (v < 0) return '0;
            if (v > longint'(OUT_MAX)) return OUT_MAX;
            return v[32:0];
        endfunction

        // Works out the radii for one accepted request and queues them.
        function void note_request(logic [30:0] lat, logic [16:0] elev);
            logic [63:0] mag, lat64, e2, s2, d, q, rn, r, rm, a64, sum_u, cos_u;
            longint      x, y, z, dx, dy, h_mm, cosv, sinv, sum;
            radii_t      res;
            lat64 = {33'd0, lat};
            mag   = lat[30] ? (64'h8000_0000 - lat64) : lat64;
            if (mag > 64'(LAT_MAX)) mag = 64'(LAT_MAX);
            h_mm = longint'($signed(elev)) * 100;

            x = longint'(INV_GAIN);
            y = 0;
            z = longint'((mag * {31'd0, DEG_TO_RAD_C}) >> 32);
            for (int i = 0; i < ANGLE_ITER_DFLT; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_Q30[i]);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_Q30[i]);
                end
            end
            cosv = (x < 0) ? 0 : (x > ONE_Q30) ? longint'(ONE_Q30) : x;
            sinv = (y < 0) ? 0 : (y > ONE_Q30) ? longint'(ONE_Q30) : y;

            e2  = {37'd0, ecc_q32};
            a64 = {31'd0, axis_mm};
            s2  = (64'(sinv) * 64'(sinv)) >> 30;
            d   = TWO_POW_32 - ((e2 * s2) >> 30);
            q   = int_sqrt(d << 30);
            if (q == 0) q = 1;
            rn  = (a64 << 31) / q;
            r   = ((TWO_POW_32 - e2) << 30) / d;
            rm  = (rn * r) >> 30;

            res.lat_mm = saturate(longint'(rm) + h_mm);
            sum = longint'(rn) + h_mm;
            if (sum < 0) begin
                res.lon_mm = '0;
            end else begin
                sum_u = 64'(sum);
                cos_u = 64'(cosv);
                res.lon_mm = saturate(longint'((sum_u * cos_u) >> 30));
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [32:0] lat_mm, logic [32:0] lon_mm);
            radii_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result lat=%0d lon=%0d", $realtime, lat_mm, lon_mm);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (lat_mm !== exp_r.lat_mm) begin
                $display("%0t: mm_per_rad_lat mismatch exp=%0d act=%0d",
                         $realtime, exp_r.lat_mm, lat_mm);
                errors++;
            end
            if (lon_mm !== exp_r.lon_mm) begin
                $display("%0t: mm_per_rad_lon mismatch exp=%0d act=%0d",
                         $realtime, exp_r.lon_mm, lon_mm);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [32:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [30:0] s_latitude_e7;
    logic signed [16:0] s_elevation_dm;
    logic               m_valid;
    logic               m_ready;
    logic [32:0]        m_mm_per_rad_lat;
    logic [32:0]        m_mm_per_rad_lon;

    mpr_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int cycle_count;

    geodetic_meters_per_radian u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_latitude_e7    (s_latitude_e7),
        .s_elevation_dm   (s_elevation_dm),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mm_per_rad_lat (m_mm_per_rad_lat),
        .m_mm_per_rad_lon (m_mm_per_rad_lon)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_latitude_e7, s_elevation_dm);
            if (m_valid && m_ready) sb.check_result(m_mm_per_rad_lat, m_mm_per_rad_lon);
        end
    end

    // result side: long hold-off when asked, else random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_request(logic [30:0] lat, logic [16:0] elev);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_latitude_e7  = lat;
        s_elevation_dm = elev;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic random_request();
        logic [30:0] lat;
        logic [16:0] elev;
        if ($urandom_range(0, 9) == 0) begin
            lat  = 31'($urandom);
            elev = 17'($urandom);
        end else begin
            lat  = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
            elev = 17'(int'($urandom_range(0, 65535)) - 4096);
        end
        send_request(lat, elev);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [32:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [32:0] axis_set [6];
        logic [32:0] ecc_set  [6];
        cycle_count    = 0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SEMI_MAJOR;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_latitude_e7  = '0;
        s_elevation_dm = '0;
        m_ready        = 1'b0;
        axis_set = '{A_RESET, 33'd6300000000, 33'd6400000000, 33'd0,
                     33'h1_FFFF_FFFF, 33'd6378137000};
        ecc_set  = '{33'(E2_RESET), 33'd0, 33'd67108864, 33'd28752143,
                     33'd67108864, 33'h1_FFFF_FFFF};
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < 6; phase++) begin
            unique case (phase % 3)
                0: begin send_idle_pct = 14; recv_idle_pct = 64; end
                1: begin send_idle_pct = 64; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase > 0) begin
                wait_drained();
                write_reg(REG_SEMI_MAJOR, axis_set[phase]);
                // wide value: upper bits beyond the register are dropped
                write_reg(REG_ECC_SQ, ecc_set[phase]);
                // writes past the register list must be ignored
                write_reg(REG_SPARE_2, 33'($urandom));
                write_reg(REG_SPARE_3, 33'($urandom));
            end
            if (phase == 2) hold_left = 600;
            if (phase == 0) begin
                send_request(31'sd0, 17'sd0);
                send_request(31'sd900000000, 17'sd0);
                send_request(-31'sd900000000, 17'sd0);
                send_request(31'sd900000001, 17'sd61439);
                send_request(-31'sd900000001, -17'sd4096);
                send_request(31'h3FFF_FFFF, 17'sd100);
                send_request(31'h4000_0000, 17'sd100);
                send_request(31'sd1, 17'h0FFFF);
                send_request(-31'sd1, 17'h10000);
                send_request(31'sd450000000, 17'sd61439);
                send_request(-31'sd450000000, -17'sd4096);
                send_request(31'sd899999999, 17'sd12345);
                send_request(31'h7FFF_FFFF, 17'h1FFFF);
            end
            for (int n = 0; n < 283; n++) random_request();
        end

        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
